### src/hps_pkg.sv
`timescale 1ns / 1ps
// Shared types, control word layout and microprogram of the phase splitter.
package hps_pkg;

    localparam int STEP_COUNT = 5;
    localparam int STEP_BITS  = $clog2(STEP_COUNT);

    typedef logic [STEP_BITS-1:0] step_t;

    // step condition: stay on the step until it holds
    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN,
        COND_OUT
    } cond_t;

    // minuend of the multiplier difference
    typedef enum logic [1:0] {
        OPA_Y2,
        OPA_W2,
        OPA_P2,
        OPA_Q2
    } opa_t;

    // subtrahend of the multiplier difference
    typedef enum logic [1:0] {
        OPB_X1,
        OPB_X,
        OPB_Y,
        OPB_P
    } opb_t;

    typedef enum logic [1:0] {
        COEF_FIRST_A,
        COEF_FIRST_B,
        COEF_SECOND_A,
        COEF_SECOND_B
    } coef_t;

    // term added to the rounded product
    typedef enum logic [1:0] {
        ADD_X3,
        ADD_X2,
        ADD_Y2,
        ADD_P2
    } addend_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_Y,
        DST_P,
        DST_O1,
        DST_O2
    } dst_t;

    typedef enum logic {
        SAT_MID,
        SAT_SAMPLE
    } sat_t;

    typedef struct packed {
        cond_t   cond;
        step_t   next_step;
        logic    mul_en;
        opa_t    opa;
        opb_t    opb;
        coef_t   coef;
        dst_t    dst;
        addend_t addend;
        sat_t    sat;
        logic    commit;
    } ctrl_word_t;

    // Steps 1 to 3 finish the product of the step before and launch the next
    // multiply in the same cycle; step 0 only launches, step 4 only finishes.
    function automatic ctrl_word_t ucode(step_t s);
        ctrl_word_t w;
        w = '{cond: COND_NONE, next_step: '0, mul_en: 1'b0, opa: OPA_Y2, opb: OPB_X1,
              coef: COEF_FIRST_A, dst: DST_NONE, addend: ADD_X3, sat: SAT_MID,
              commit: 1'b0};
        case (s)
            step_t'(0):
            begin
                w.cond      = COND_IN;
                w.next_step = step_t'(1);
                w.mul_en    = 1'b1;
                w.opa       = OPA_Y2;
                w.opb       = OPB_X1;
                w.coef      = COEF_FIRST_A;
            end
            step_t'(1):
            begin
                w.next_step = step_t'(2);
                w.dst       = DST_Y;
                w.addend    = ADD_X3;
                w.sat       = SAT_MID;
                w.mul_en    = 1'b1;
                w.opa       = OPA_P2;
                w.opb       = OPB_X;
                w.coef      = COEF_SECOND_A;
            end
            step_t'(2):
            begin
                w.next_step = step_t'(3);
                w.dst       = DST_P;
                w.addend    = ADD_X2;
                w.sat       = SAT_MID;
                w.mul_en    = 1'b1;
                w.opa       = OPA_W2;
                w.opb       = OPB_Y;
                w.coef      = COEF_FIRST_B;
            end
            step_t'(3):
            begin
                w.next_step = step_t'(4);
                w.dst       = DST_O1;
                w.addend    = ADD_Y2;
                w.sat       = SAT_SAMPLE;
                w.mul_en    = 1'b1;
                w.opa       = OPA_Q2;
                w.opb       = OPB_P;
                w.coef      = COEF_SECOND_B;
            end
            step_t'(4):
            begin
                w.cond      = COND_OUT;
                w.next_step = step_t'(0);
                w.dst       = DST_O2;
                w.addend    = ADD_P2;
                w.sat       = SAT_SAMPLE;
                w.commit    = 1'b1;
            end
            default:
            begin
                w.next_step = step_t'(0);
            end
        endcase
        return w;
    endfunction

endpackage

### src/iir_hilbert_phase_splitter_unit.sv
`timescale 1ns / 1ps
// Top level of the IIR allpass Hilbert phase splitter.
//
// One signed sample enters on the s_axis channel and one result pair
// (two allpass branch outputs in quadrature) leaves on the m_axis channel.
// A five-step microprogram drives one shared multiplier: the four
// multiplies of a sample run back to back, each product is registered,
// then rounded, summed and saturated in the next step.
// The result enters the output register when the commit step fires.
// A new sample is taken only after the last one has passed all five steps,
// as the shared multiplier and the delay lines serve one sample at a time.
// s_axis_tready is high only on the first program step; the output register
// frees the datapath, so the next sample is taken while a result waits.
// If the receiver stalls with a result still held, the commit step waits.
// Reset clears the step counter, the output valid flag and all eleven
// delay registers to zero.
module iir_hilbert_phase_splitter_unit #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, zero padded to bytes
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]       s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // out_first, then out_second, zero padded to bytes
    output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   m_axis_tdata
);

    localparam int OUT_BYTES_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    hps_pkg::ctrl_word_t ctrl;
    logic                fire;
    logic                out_free;
    logic                out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_first_reg, out_second_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_first, res_second;
    logic                commit;

    assign out_free = !out_valid_reg || m_axis_tready;

    hps_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .fire     (fire)
    );

    hps_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .fire       (fire),
        .sample     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .res_first  (res_first),
        .res_second (res_second)
    );

    assign s_axis_tready = (ctrl.cond == hps_pkg::COND_IN);
    assign commit        = fire && ctrl.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_first_reg  <= res_first;
            out_second_reg <= res_second;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BYTES_W'({out_second_reg, out_first_reg});

endmodule

### src/hps_sequencer.sv
`timescale 1ns / 1ps
// Step counter and control store of the phase splitter.
module hps_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_free,
    output hps_pkg::ctrl_word_t ctrl,
    output logic               fire
);

    hps_pkg::step_t step_reg;
    hps_pkg::step_t step_next;

    assign ctrl = hps_pkg::ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            hps_pkg::COND_IN:  fire = in_valid;
            hps_pkg::COND_OUT: fire = out_free;
            default:           fire = 1'b1;
        endcase
        step_next = fire ? ctrl.next_step : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

### src/hps_datapath.sv
`timescale 1ns / 1ps
// Delay registers, shared multiplier, rounding and saturation of the phase splitter.
module hps_datapath #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hps_pkg::ctrl_word_t            ctrl,
    input  logic                           fire,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SAMPLE_WIDTH-1:0] res_first,
    output logic signed [SAMPLE_WIDTH-1:0] res_second
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int MIDW = SAMPLE_WIDTH + 2;
    localparam int DW   = SAMPLE_WIDTH + 3;
    localparam int CW   = COEF_FRAC_BITS + 1;
    localparam int PW   = DW + CW + 1;
    localparam int RW   = PW - COEF_FRAC_BITS;
    localparam int SUMW = RW + 1;

    localparam longint C0 = ((longint'(94167) <<< COEF_FRAC_BITS) + 50000) / 100000;
    localparam longint C1 = ((longint'(53239) <<< COEF_FRAC_BITS) + 50000) / 100000;
    localparam longint C2 = ((longint'(186540) <<< COEF_FRAC_BITS) + 500000) / 1000000;
    localparam longint C3 = ((longint'(7902015) <<< COEF_FRAC_BITS) + 5000000) / 10000000;

    localparam logic [CW-1:0] COEF0 = CW'(C0);
    localparam logic [CW-1:0] COEF1 = CW'(C1);
    localparam logic [CW-1:0] COEF2 = CW'(C2);
    localparam logic [CW-1:0] COEF3 = CW'(C3);

    localparam logic signed [PW-1:0]   HALF   = PW'(longint'(1) <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [SUMW-1:0] MID_HI = SUMW'((longint'(1) <<< (MIDW - 1)) - 1);
    localparam logic signed [SUMW-1:0] MID_LO = -MID_HI - SUMW'(1);
    localparam logic signed [SUMW-1:0] SMP_HI = SUMW'((longint'(1) <<< (SW - 1)) - 1);
    localparam logic signed [SUMW-1:0] SMP_LO = -SMP_HI - SUMW'(1);

    logic signed [SW-1:0]   x_reg, x1_reg, x2_reg, x3_reg;
    logic signed [MIDW-1:0] y1_reg, y2_reg, p1_reg, p2_reg;
    logic signed [SW-1:0]   w1_reg, w2_reg, q1_reg, q2_reg;
    logic signed [MIDW-1:0] y_reg, p_reg;
    logic signed [SW-1:0]   o1_reg;
    logic signed [PW-1:0]   prod_reg;

    logic signed [DW-1:0]   opa, opb, diff;
    logic [CW-1:0]          coef;
    logic signed [PW-1:0]   prod;
    logic signed [RW-1:0]   rnd;
    logic signed [SUMW-1:0] addend, sum, sat_val;
    logic signed [MIDW-1:0] fin;
    logic signed [SW-1:0]   fin_smp;
    logic                   accept_x;

    always_comb
    begin
        case (ctrl.opa)
            hps_pkg::OPA_Y2: opa = DW'(y2_reg);
            hps_pkg::OPA_W2: opa = DW'(w2_reg);
            hps_pkg::OPA_P2: opa = DW'(p2_reg);
            default:         opa = DW'(q2_reg);
        endcase
        // the newest sample sits in x_reg from the step after the accept step on
        case (ctrl.opb)
            hps_pkg::OPB_X1: opb = DW'(x1_reg);
            hps_pkg::OPB_X:  opb = DW'(x_reg);
            hps_pkg::OPB_Y:  opb = DW'(y_reg);
            default:         opb = DW'(p_reg);
        endcase
        case (ctrl.coef)
            hps_pkg::COEF_FIRST_A:  coef = COEF0;
            hps_pkg::COEF_FIRST_B:  coef = COEF1;
            hps_pkg::COEF_SECOND_A: coef = COEF2;
            default:                coef = COEF3;
        endcase
        case (ctrl.addend)
            hps_pkg::ADD_X3: addend = SUMW'(x3_reg);
            hps_pkg::ADD_X2: addend = SUMW'(x2_reg);
            hps_pkg::ADD_Y2: addend = SUMW'(y2_reg);
            default:         addend = SUMW'(p2_reg);
        endcase
    end

    assign diff = opa - opb;
    assign prod = PW'(diff) * PW'(signed'({1'b0, coef}));

    // round half up, then add the direct term and clamp
    assign rnd = RW'((prod_reg + HALF) >>> COEF_FRAC_BITS);
    assign sum = SUMW'(rnd) + addend;

    always_comb
    begin
        if (ctrl.sat == hps_pkg::SAT_MID)
            sat_val = (sum > MID_HI) ? MID_HI : ((sum < MID_LO) ? MID_LO : sum);
        else
            sat_val = (sum > SMP_HI) ? SMP_HI : ((sum < SMP_LO) ? SMP_LO : sum);
    end

    assign fin     = sat_val[MIDW-1:0];
    assign fin_smp = sat_val[SW-1:0];

    assign res_first  = o1_reg;
    assign res_second = fin_smp;

    assign accept_x = fire && (ctrl.cond == hps_pkg::COND_IN);

    always_ff @(posedge clk)
    begin
        if (accept_x)
            x_reg <= sample;
        if (fire && ctrl.mul_en)
            prod_reg <= prod;
        if (fire && ctrl.dst == hps_pkg::DST_Y)
            y_reg <= fin;
        if (fire && ctrl.dst == hps_pkg::DST_P)
            p_reg <= fin;
        if (fire && ctrl.dst == hps_pkg::DST_O1)
            o1_reg <= fin_smp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            x3_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            q1_reg <= '0;
            q2_reg <= '0;
        end
        else if (fire && ctrl.commit)
        begin
            x3_reg <= x2_reg;
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= y_reg;
            w2_reg <= w1_reg;
            w1_reg <= o1_reg;
            p2_reg <= p1_reg;
            p1_reg <= p_reg;
            q2_reg <= q1_reg;
            q1_reg <= fin_smp;
        end
    end

endmodule

### verif/tb_iir_hilbert_phase_splitter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IIR allpass Hilbert phase splitter unit.
module tb_iir_hilbert_phase_splitter_unit;

    localparam int  SW          = 16;
    localparam int  FRAC        = 15;
    localparam int  MW          = SW + 2;
    localparam int  QUIET_LIMIT = 4000;
    localparam int  PRINT_MAX   = 40;

    // branch coefficients, Q1.15 rounded to nearest
    localparam longint K_FIRST_A  = ((longint'(94167) << FRAC) + 50000) / 100000;
    localparam longint K_FIRST_B  = ((longint'(53239) << FRAC) + 50000) / 100000;
    localparam longint K_SECOND_A = ((longint'(186540) << FRAC) + 500000) / 1000000;
    localparam longint K_SECOND_B = ((longint'(7902015) << FRAC) + 5000000) / 10000000;

    localparam logic signed [SW-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SW-1:0] S_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [SW-1:0] second;
        logic signed [SW-1:0] first;
    } quad_pair_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [SW-1:0]    s_axis_tdata;   // [15:0] sample_in
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [2*SW-1:0]  m_axis_tdata;   // [15:0] out_first, [31:16] out_second

    quad_pair_t pair_due[$];
    int         error_count   = 0;
    int         result_index  = 0;
    int         quiet_cycles  = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_len      = 0;
    logic       holding       = 1'b0;
    event       hold_go;

    // predictor state: input history x1..x3 and the section delays
    longint x_hist[3]     = '{default: 0};
    longint first_mid[2]  = '{default: 0};
    longint first_out[2]  = '{default: 0};
    longint second_mid[2] = '{default: 0};
    longint second_out[2] = '{default: 0};

    iir_hilbert_phase_splitter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // coef * diff rounded half up to an integer
    function automatic longint scale_round(input longint coef, input longint diff);
        return (coef * diff + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    // advance the phase splitter by one sample and return the output pair
    function automatic quad_pair_t predict_pair(input logic signed [SW-1:0] smp);
        quad_pair_t r;
        longint x;
        longint y;
        longint o1;
        longint p;
        longint o2;
        x  = longint'(smp);
        y  = clamp(scale_round(K_FIRST_A, first_mid[1] - x_hist[0]) + x_hist[2], MW);
        o1 = clamp(scale_round(K_FIRST_B, first_out[1] - y) + first_mid[1], SW);
        p  = clamp(scale_round(K_SECOND_A, second_mid[1] - x) + x_hist[1], MW);
        o2 = clamp(scale_round(K_SECOND_B, second_out[1] - p) + second_mid[1], SW);
        first_mid[1]  = first_mid[0];
        first_mid[0]  = y;
        first_out[1]  = first_out[0];
        first_out[0]  = o1;
        second_mid[1] = second_mid[0];
        second_mid[0] = p;
        second_out[1] = second_out[0];
        second_out[0] = o2;
        x_hist[2] = x_hist[1];
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        r.first  = o1[SW-1:0];
        r.second = o2[SW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int idx, input int got_v,
                                   input int want_v);
        if (error_count < PRINT_MAX)
            $display("%0t: mismatch on result %0d: %s got %0d expected %0d",
                     $realtime, idx, what, got_v, want_v);
        error_count++;
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_sample(input logic signed [SW-1:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= SW'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pair_due.push_back(predict_pair(smp));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pair_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        logic signed [SW-1:0] seq[$];
        seq = '{S_MAX, 0, 0, 0, S_MIN, 0, 0, 0,
                S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN,
                S_MAX, S_MIN, S_MAX, S_MIN, 16'sd1, -16'sd1, 16'sh5555, -16'sh5556};
        foreach (seq[i])
            push_sample(seq[i]);
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    // bursts of noise, full-scale extremes, small values and square waves
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int sent;
        int kind;
        int len;
        int period;
        int amp;
        logic signed [SW-1:0] smp;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            kind   = $urandom_range(3);
            len    = $urandom_range(40, 4);
            period = $urandom_range(8, 2);
            amp    = $urandom_range(32767, 1);
            for (int i = 0; i < len && sent < count; i++)
            begin
                case (kind)
                    0: smp = SW'($urandom);
                    1: smp = $urandom_range(1) ? S_MAX : S_MIN;
                    2: smp = SW'($signed($urandom_range(510)) - 255);
                    default: smp = ((i % period) < period / 2) ? SW'(amp) : SW'(-amp - 1);
                endcase
                push_sample(smp);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while samples keep coming, so the input stalls
    task automatic test_output_stall();
        hold_len = 300;
        -> hold_go;
        for (int i = 0; i < 30; i++)
            push_sample(SW'($urandom));
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    always
    begin
        @(hold_go);
        holding = 1'b1;
        repeat (hold_len) @(posedge clk);
        holding = 1'b0;
    end

    always @(negedge clk)
    begin
        if (holding)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        quad_pair_t got;
        quad_pair_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = quad_pair_t'(m_axis_tdata);
            if (pair_due.size() == 0)
                report_mismatch("unexpected transfer, out_first", result_index,
                                got.first, 0);
            else
            begin
                want = pair_due.pop_front();
                if (got.first !== want.first)
                    report_mismatch("out_first", result_index, got.first, want.first);
                if (got.second !== want.second)
                    report_mismatch("out_second", result_index, got.second, want.second);
            end
            result_index++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(220, 0, 0);
        test_random(220, 85, 0);
        test_random(220, 0, 85);
        test_random(220, 27, 27);
        test_output_stall();
        test_random(40, 0, 0);

        repeat (12) @(posedge clk);
        if (pair_due.size() != 0)
            report_mismatch("results left over", result_index, pair_due.size(), 0);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
